FILE: rtl/core/led_color_fade_stepper_top_assert.svh
// assertion macros for the led colour fade stepper
// taken in by the top level, no other dependencies
`ifndef LED_COLOR_FADE_STEPPER_TOP_ASSERT_SVH
`define LED_COLOR_FADE_STEPPER_TOP_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define LCFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent in the following cycle
`define LCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lcfs_pkg.sv
// shared types and constants for the led colour fade stepper
// no dependencies, imported by the top level of the block
`default_nettype none

package lcfs_pkg;

  localparam int unsigned LCFS_STEP_PERIOD_MS  = 20;
  localparam int unsigned LCFS_DUTY_FULL_SCALE = 4000;

  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned DUR_W     = 11;
  localparam int unsigned DUTY_W    = 12;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned MAX_STEPS = 63;
  localparam int unsigned COLOR_MAX = 255;
  localparam int unsigned NUM_CHAN  = 3;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 2;

  localparam logic [SEL_W-1:0] GRP_BOTH = 2'd0;
  localparam logic [SEL_W-1:0] GRP_A    = 2'd1;
  localparam logic [SEL_W-1:0] GRP_B    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SPLIT,
    ST_SPLIT_WAIT,
    ST_DUTY,
    ST_DUTY_WAIT
  } lcfs_state_e;

  typedef logic [COLOR_W-1:0] color_t;

endpackage

`default_nettype wire

FILE: rtl/core/lcfs_div_lane.sv
// bit-serial restoring divider, one quotient bit per cycle
// used as the arithmetic lanes of the fade stepper, one per colour channel, no package needs
`default_nettype none

module lcfs_div_lane #(
  parameter int unsigned NUM_W = 21,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // quotient bits fill the numerator register from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/led_color_fade_stepper_top.sv
// led colour fade stepper, top level: sequencer, group colours, output register
// depends on lcfs_pkg, lcfs_div_lane and the assertion macro header
//
// Usage
//   Slave channel: one fade command per word, target colour, duration in ms
//   and group selector. Master channel: one word per step with three 12-bit
//   duties and the group flags in tuser; tlast marks the final step, which
//   always carries the target colour.
//   A command yields min(duration / STEP_PERIOD_MS, 63) words, at least one.
//   Three bit-serial divider lanes (one per colour channel) do the divisions,
//   NUM_W = max(8 + bits of full scale, 11) bits wide: 20 with the default
//   full scale. A command runs one pass for the step count, one for the
//   per-step increment (skipped for a single step) and one per output word.
//   The next command is taken once the final word sits in the output register.
//   A stalled receiver holds the word in the output register; the lanes stop
//   with the next word ready until the register frees.
//   Reset sets both group colours to black and empties the output register.
`default_nettype none
`include "led_color_fade_stepper_top_assert.svh"

module led_color_fade_stepper_top #(
  parameter int unsigned STEP_PERIOD_MS  = lcfs_pkg::LCFS_STEP_PERIOD_MS,
  parameter int unsigned DUTY_FULL_SCALE = lcfs_pkg::LCFS_DUTY_FULL_SCALE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // target_red, target_green, target_blue, duration_ms, zero fill
  input  logic [lcfs_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // group_select
  input  logic [lcfs_pkg::SEL_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // duty_red, duty_green, duty_blue, zero fill
  output logic [lcfs_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // apply_group_a, apply_group_b
  output logic [lcfs_pkg::M_TUSER_W-1:0]  m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  import lcfs_pkg::*;

  localparam int unsigned PROD_W = COLOR_W + $clog2(DUTY_FULL_SCALE + 1);
  localparam int unsigned NUM_W  = (PROD_W > DUR_W) ? PROD_W : DUR_W;
  localparam int unsigned PER_W  = $clog2(STEP_PERIOD_MS + 1);
  localparam int unsigned DEN_W  = (PER_W > COLOR_W) ? PER_W : COLOR_W;

  lcfs_state_e state_q, state_d;

  logic accept;
  logic out_free;
  logic lanes_done;
  logic lane_start;
  logic load_out;

  logic [NUM_CHAN-1:0] lane_done;
  logic [NUM_W-1:0]    lane_num [NUM_CHAN];
  logic [DEN_W-1:0]    lane_den [NUM_CHAN];
  logic [NUM_W-1:0]    lane_quo [NUM_CHAN];
  logic [DEN_W-1:0]    lane_rem [NUM_CHAN];

  color_t tgt_q  [NUM_CHAN];
  color_t old_q  [NUM_CHAN];
  color_t grp_a_q [NUM_CHAN];
  color_t grp_b_q [NUM_CHAN];
  color_t qinc_q [NUM_CHAN];
  color_t acc_q  [NUM_CHAN];
  logic [STEP_W-1:0] rinc_q [NUM_CHAN];
  logic [STEP_W-1:0] res_q  [NUM_CHAN];

  color_t absdiff [NUM_CHAN];
  logic   neg     [NUM_CHAN];
  color_t cur     [NUM_CHAN];
  color_t acc_d   [NUM_CHAN];
  logic [STEP_W-1:0] res_d [NUM_CHAN];

  logic [STEP_W-1:0] steps_q;
  logic [STEP_W-1:0] steps_sat;
  logic [STEP_W-1:0] idx_q;
  logic              last_q;
  logic              app_a_q;
  logic              app_b_q;
  logic              next_last;

  logic              m_valid_q;
  logic [DUTY_W-1:0] duty_q [NUM_CHAN];
  logic              m_app_a_q;
  logic              m_app_b_q;
  logic              m_last_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign lanes_done      = &lane_done;

  // step count saturates at the longest fade
  assign steps_sat = (lane_quo[0] > NUM_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                       : lane_quo[0][STEP_W-1:0];

  // the word after this one is the final one when idx + 2 reaches steps
  assign next_last = ({1'b0, idx_q} + (STEP_W+1)'(2)) >= {1'b0, steps_q};

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      logic [STEP_W:0] rsum;
      logic [STEP_W:0] rsub;
      logic            wrap;
      neg[k]     = tgt_q[k] < old_q[k];
      absdiff[k] = neg[k] ? (old_q[k] - tgt_q[k]) : (tgt_q[k] - old_q[k]);
      cur[k]     = last_q ? tgt_q[k]
                 : (neg[k] ? (old_q[k] - acc_q[k]) : (old_q[k] + acc_q[k]));
      // running quotient and remainder of |diff| * idx / steps
      rsum       = {1'b0, res_q[k]} + {1'b0, rinc_q[k]};
      rsub       = rsum - {1'b0, steps_q};
      wrap       = rsum >= {1'b0, steps_q};
      res_d[k]   = wrap ? rsub[STEP_W-1:0] : rsum[STEP_W-1:0];
      acc_d[k]   = acc_q[k] + qinc_q[k] + COLOR_W'(wrap);
    end
  end

  // operands for the divider lanes, chosen by phase
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(cur[k]) * PROD_W'(DUTY_FULL_SCALE);
      case (state_q)
        ST_IDLE: begin
          lane_num[k] = (k == 0) ? NUM_W'(s_axis_tdata_i[3*COLOR_W +: DUR_W]) : '0;
          lane_den[k] = DEN_W'(STEP_PERIOD_MS);
        end
        ST_SPLIT: begin
          lane_num[k] = NUM_W'(absdiff[k]);
          lane_den[k] = DEN_W'(steps_q);
        end
        default: begin
          lane_num[k] = NUM_W'(prod);
          lane_den[k] = DEN_W'(COLOR_MAX);
        end
      endcase
    end
  end

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    lcfs_div_lane #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .num_i   (lane_num[k]),
      .den_i   (lane_den[k]),
      .done_o  (lane_done[k]),
      .quo_o   (lane_quo[k]),
      .rem_o   (lane_rem[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    lane_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          lane_start = 1'b1;
          state_d    = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (lane_done[0]) begin
          state_d = (steps_sat < STEP_W'(2)) ? ST_DUTY : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        lane_start = 1'b1;
        state_d    = ST_SPLIT_WAIT;
      end
      ST_SPLIT_WAIT: begin
        if (lanes_done) begin
          state_d = ST_DUTY;
        end
      end
      ST_DUTY: begin
        lane_start = 1'b1;
        state_d    = ST_DUTY_WAIT;
      end
      ST_DUTY_WAIT: begin
        if (lanes_done && out_free) begin
          load_out = 1'b1;
          state_d  = last_q ? ST_IDLE : ST_DUTY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fade working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        tgt_q[k] <= s_axis_tdata_i[(NUM_CHAN-1-k)*0 + k*COLOR_W +: COLOR_W];
        old_q[k] <= (s_axis_tuser_i == GRP_A) ? grp_a_q[k] : grp_b_q[k];
      end
      app_a_q <= (s_axis_tuser_i == GRP_BOTH) || (s_axis_tuser_i == GRP_A);
      app_b_q <= (s_axis_tuser_i == GRP_BOTH) || (s_axis_tuser_i == GRP_B);
    end
    if (state_q == ST_COUNT && lane_done[0]) begin
      steps_q <= steps_sat;
      last_q  <= steps_sat < STEP_W'(2);
      idx_q   <= '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
        acc_q[k] <= '0;
        res_q[k] <= '0;
      end
    end
    if (state_q == ST_SPLIT_WAIT && lanes_done) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        qinc_q[k] <= lane_quo[k][COLOR_W-1:0];
        rinc_q[k] <= lane_rem[k][STEP_W-1:0];
      end
    end
    if (load_out && !last_q) begin
      idx_q  <= idx_q + STEP_W'(1);
      last_q <= next_last;
      for (int k = 0; k < NUM_CHAN; k++) begin
        acc_q[k] <= acc_d[k];
        res_q[k] <= res_d[k];
      end
    end
    if (load_out) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        duty_q[k] <= lane_quo[k][DUTY_W-1:0];
      end
      m_app_a_q <= app_a_q;
      m_app_b_q <= app_b_q;
      m_last_q  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      for (int k = 0; k < NUM_CHAN; k++) begin
        grp_a_q[k] <= '0;
        grp_b_q[k] <= '0;
      end
    end else begin
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      // the selected groups take the target colour when the final word is loaded
      if (load_out && last_q) begin
        for (int k = 0; k < NUM_CHAN; k++) begin
          if (app_a_q) begin
            grp_a_q[k] <= tgt_q[k];
          end
          if (app_b_q) begin
            grp_b_q[k] <= tgt_q[k];
          end
        end
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - NUM_CHAN*DUTY_W){1'b0}},
                            duty_q[2], duty_q[1], duty_q[0]};
  assign m_axis_tuser_o  = {m_app_b_q, m_app_a_q};
  assign m_axis_tlast_o  = m_last_q;

  `LCFS_ASSERT_NOW(a_lanes_lockstep, clk_i, rst_ni, 1'b1,
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]),
    "divider lanes out of step")
  `LCFS_ASSERT_NOW(a_step_in_range, clk_i, rst_ni, state_q == ST_DUTY,
    last_q || (({1'b0, idx_q} + (STEP_W+1)'(1)) < {1'b0, steps_q}),
    "intermediate step index past step count")
  `LCFS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept,
    !s_axis_tready_o && !load_out,
    "command accepted while a fade is running")

endmodule

`default_nettype wire
